// ----- design/ppm_pkg.sv -----
package ppm_pkg;

    localparam int ACC_W = 16;
    localparam logic [ACC_W-1:0] COLOR_MAX = 16'hFFFF;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_BAD_MAGIC = 2'd0;
    localparam logic [1:0] ERR_GRAYSCALE = 2'd1;
    localparam logic [1:0] ERR_NON_DIGIT = 2'd2;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd3;

    typedef enum logic [3:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_W_SKIP,
        PH_W_DIG,
        PH_H_SKIP,
        PH_H_DIG,
        PH_M_SKIP,
        PH_M_DIG,
        PH_PIXELS,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [15:0] max_color;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
        logic [1:0]  error_code;
    } t_out_word;

endpackage

// ----- design/ppm_header_and_pixel_parser_unit.sv -----
// channel | valid       | stall       | word
// input   | i_in_valid  | o_in_stall  | i_in_data  (byte of the file, restart flag)
// output  | o_out_valid | i_out_stall | o_out_data (header, pixel or error)
//
// one byte per cycle while o_in_stall is low; each result is registered before it is offered
// the parser state updates in the cycle a byte is taken, results go to an output
// register backed by one skid register, so o_in_stall rises only when both are full
// i_rst_n is synchronous, active low, and puts the parser at the first magic byte
module ppm_header_and_pixel_parser_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ppm_pkg::t_in_word   i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output ppm_pkg::t_out_word  o_out_data,
    input  logic                i_out_stall
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int WX = (DW > 13) ? DW : 13;
    localparam int CX = (DW > 12) ? DW : 12;
    localparam int VW = ppm_pkg::ACC_W + 4;
    localparam logic [VW-1:0] DIM_LIMIT   = VW'(MAX_DIM);
    localparam logic [VW-1:0] COLOR_LIMIT = VW'(ppm_pkg::COLOR_MAX);

    ppm_pkg::t_phase           r_phase, n_phase, cur_phase;
    logic                      r_in_comment, n_in_comment, cur_comment;
    logic [ppm_pkg::ACC_W-1:0] r_accum, n_accum;
    logic [DW-1:0]             r_width, n_width;
    logic [DW-1:0]             r_height, n_height;
    logic [1:0]                r_bip, n_bip;
    logic [7:0]                r_red, n_red;
    logic [7:0]                r_green, n_green;
    logic [DW-1:0]             r_col, n_col;
    logic [DW-1:0]             r_row, n_row;

    logic                      r_out_valid;
    ppm_pkg::t_out_word        r_out;
    logic                      r_skid_valid;
    ppm_pkg::t_out_word        r_skid;

    logic                      in_acc;
    logic                      out_take;
    logic                      res_valid;
    ppm_pkg::t_out_word        res;
    logic [7:0]                d;
    logic                      is_digit;
    logic                      is_space;
    logic                      is_eol;
    logic [VW-1:0]             digit_v;
    logic [VW-1:0]             acc_v;
    logic [VW-1:0]             acc_lim;
    logic [DW:0]               col_p1;
    logic [DW:0]               row_p1;
    logic [WX-1:0]             w_ext;
    logic [WX-1:0]             h_ext;
    logic [CX-1:0]             c_ext;
    logic [CX-1:0]             rw_ext;

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_acc   = i_in_valid & ~r_skid_valid;
    assign out_take = r_out_valid & ~i_out_stall;

    assign d        = i_in_data.data_byte;
    assign is_digit = (d >= ppm_pkg::CH_ZERO) && (d <= ppm_pkg::CH_NINE);
    assign is_eol   = (d == ppm_pkg::CH_LF) || (d == ppm_pkg::CH_CR);
    assign is_space = is_eol || (d == ppm_pkg::CH_SPACE) || (d == ppm_pkg::CH_TAB);
    assign digit_v  = VW'(d[3:0]);

    // accum * 10 as two shifted copies
    assign acc_v = VW'({r_accum, 3'b000}) + VW'({r_accum, 1'b0}) + digit_v;
    assign acc_lim = (cur_phase == ppm_pkg::PH_M_DIG) ? COLOR_LIMIT : DIM_LIMIT;

    assign col_p1 = (DW + 1)'(r_col) + (DW + 1)'(1);
    assign row_p1 = (DW + 1)'(r_row) + (DW + 1)'(1);
    assign w_ext  = WX'(r_width);
    assign h_ext  = WX'(r_height);
    assign c_ext  = CX'(r_col);
    assign rw_ext = CX'(r_row);

    // a restart only needs to reset phase and comment: every other register
    // is written before it is read within one file
    assign cur_phase   = i_in_data.start_req ? ppm_pkg::PH_MAGIC0 : r_phase;
    assign cur_comment = i_in_data.start_req ? 1'b0 : r_in_comment;

    always_comb begin
        n_phase      = cur_phase;
        n_in_comment = cur_comment;
        n_accum      = r_accum;
        n_width      = r_width;
        n_height     = r_height;
        n_bip        = r_bip;
        n_red        = r_red;
        n_green      = r_green;
        n_col        = r_col;
        n_row        = r_row;
        res_valid    = 1'b0;
        res          = '0;

        if (cur_comment) begin
            if (is_eol) begin
                n_in_comment = 1'b0;
            end
        end else begin
            unique case (cur_phase)
                ppm_pkg::PH_MAGIC0: begin
                    if (d == ppm_pkg::CH_P) begin
                        n_phase = ppm_pkg::PH_MAGIC1;
                    end else begin
                        res_valid      = 1'b1;
                        res.kind       = ppm_pkg::KIND_ERROR;
                        res.error_code = ppm_pkg::ERR_BAD_MAGIC;
                        n_phase        = ppm_pkg::PH_DONE;
                    end
                end
                ppm_pkg::PH_MAGIC1: begin
                    if (d == ppm_pkg::CH_SIX) begin
                        n_phase = ppm_pkg::PH_W_SKIP;
                    end else begin
                        res_valid      = 1'b1;
                        res.kind       = ppm_pkg::KIND_ERROR;
                        res.error_code = (d == ppm_pkg::CH_FIVE) ? ppm_pkg::ERR_GRAYSCALE
                                                                 : ppm_pkg::ERR_BAD_MAGIC;
                        n_phase        = ppm_pkg::PH_DONE;
                    end
                end
                ppm_pkg::PH_W_SKIP, ppm_pkg::PH_H_SKIP, ppm_pkg::PH_M_SKIP: begin
                    priority if (is_space) begin
                        n_phase = cur_phase;
                    end else if (d == ppm_pkg::CH_HASH) begin
                        n_in_comment = 1'b1;
                    end else if (!is_digit) begin
                        res_valid      = 1'b1;
                        res.kind       = ppm_pkg::KIND_ERROR;
                        res.error_code = ppm_pkg::ERR_NON_DIGIT;
                        n_phase        = ppm_pkg::PH_DONE;
                    end else if (digit_v > ((cur_phase == ppm_pkg::PH_M_SKIP) ? COLOR_LIMIT
                                                                              : DIM_LIMIT)) begin
                        res_valid      = 1'b1;
                        res.kind       = ppm_pkg::KIND_ERROR;
                        res.error_code = ppm_pkg::ERR_TOO_LARGE;
                        n_phase        = ppm_pkg::PH_DONE;
                    end else begin
                        n_accum = ppm_pkg::ACC_W'(digit_v);
                        n_phase = ppm_pkg::t_phase'(cur_phase + 4'd1);
                    end
                end
                ppm_pkg::PH_W_DIG, ppm_pkg::PH_H_DIG, ppm_pkg::PH_M_DIG: begin
                    if (is_digit) begin
                        if (acc_v > acc_lim) begin
                            res_valid      = 1'b1;
                            res.kind       = ppm_pkg::KIND_ERROR;
                            res.error_code = ppm_pkg::ERR_TOO_LARGE;
                            n_phase        = ppm_pkg::PH_DONE;
                        end else begin
                            n_accum = acc_v[ppm_pkg::ACC_W-1:0];
                        end
                    end else begin
                        // the terminating byte is consumed; a hash opens a comment
                        n_in_comment = (d == ppm_pkg::CH_HASH);
                        priority if (cur_phase == ppm_pkg::PH_W_DIG) begin
                            n_width = r_accum[DW-1:0];
                            n_phase = ppm_pkg::PH_H_SKIP;
                        end else if (cur_phase == ppm_pkg::PH_H_DIG) begin
                            n_height = r_accum[DW-1:0];
                            n_phase  = ppm_pkg::PH_M_SKIP;
                        end else begin
                            res_valid        = 1'b1;
                            res.kind         = ppm_pkg::KIND_HEADER;
                            res.image_width  = w_ext[12:0];
                            res.image_height = h_ext[12:0];
                            res.max_color    = r_accum;
                            n_bip            = 2'd0;
                            n_col            = '0;
                            n_row            = '0;
                            if ((r_width == '0) || (r_height == '0)) begin
                                res.last     = 1'b1;
                                n_phase      = ppm_pkg::PH_DONE;
                                n_in_comment = 1'b0;
                            end else begin
                                n_phase = ppm_pkg::PH_PIXELS;
                            end
                        end
                    end
                end
                ppm_pkg::PH_PIXELS: begin
                    priority if (r_bip == 2'd0) begin
                        n_red = d;
                        n_bip = 2'd1;
                    end else if (r_bip == 2'd1) begin
                        n_green = d;
                        n_bip   = 2'd2;
                    end else begin
                        n_bip      = 2'd0;
                        res_valid  = 1'b1;
                        res.kind   = ppm_pkg::KIND_PIXEL;
                        res.red    = r_red;
                        res.green  = r_green;
                        res.blue   = d;
                        res.column = c_ext[11:0];
                        res.row    = rw_ext[11:0];
                        if ((col_p1 >= (DW + 1)'(r_width)) &&
                            (row_p1 >= (DW + 1)'(r_height))) begin
                            res.last = 1'b1;
                            n_phase  = ppm_pkg::PH_DONE;
                        end else if (col_p1 >= (DW + 1)'(r_width)) begin
                            n_col = '0;
                            n_row = row_p1[DW-1:0];
                        end else begin
                            n_col = col_p1[DW-1:0];
                        end
                    end
                end
                ppm_pkg::PH_DONE: begin
                    n_phase = ppm_pkg::PH_DONE;
                end
                default: begin
                    n_phase = cur_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ppm_pkg::PH_MAGIC0;
            r_in_comment <= 1'b0;
        end else if (in_acc) begin
            r_phase      <= n_phase;
            r_in_comment <= n_in_comment;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_accum  <= n_accum;
            r_width  <= n_width;
            r_height <= n_height;
            r_bip    <= n_bip;
            r_red    <= n_red;
            r_green  <= n_green;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    // output word register with one skid word behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= in_acc & res_valid;
        end else if (in_acc && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_take) begin
            r_out <= res;
        end else if (in_acc && res_valid) begin
            r_skid <= res;
        end
    end

endmodule
